// ----- src/flcs_pkg.sv -----
// Shared types and constants for the frame load claim scheduler.
package flcs_pkg;

    localparam int FRAME_W = 10;
    localparam int COUNT_W = 11;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FN_PRIORITIZE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLAIM      = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MARK       = 2'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY      = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] frame_index;
    } item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] claimed_frame;
        logic               claim_found;
        logic               is_loaded;
        logic               push_refused;
    } result_t;

endpackage

// ----- src/flcs_channels.sv -----
// Channel interfaces: request, response and configuration write.
interface flcs_req_if;
    logic                              valid;
    logic                              ready;
    logic [flcs_pkg::FUNC_W-1:0]       func;
    logic [flcs_pkg::FRAME_W-1:0]      frame_index;

    modport source (output valid, output func, output frame_index, input ready);
    modport sink (input valid, input func, input frame_index, output ready);
endinterface

interface flcs_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [flcs_pkg::FRAME_W-1:0]      claimed_frame;
    logic                              claim_found;
    logic                              is_loaded;
    logic                              push_refused;

    modport source (output valid, output claimed_frame, output claim_found,
                    output is_loaded, output push_refused, input ready);
    modport sink (input valid, input claimed_frame, input claim_found,
                  input is_loaded, input push_refused, output ready);
endinterface

interface flcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [flcs_pkg::COUNT_W-1:0]      frame_count;

    modport source (output valid, output frame_count, input ready);
    modport sink (input valid, input frame_count, output ready);
endinterface

// ----- src/flcs_ram.sv -----
// Generic single-port RAM with registered read.
module flcs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/flcs_ctrl.sv -----
// Sequencer: map clearing pass, request handling and the claim walk.
module flcs_ctrl #(
    parameter int MAX_FRAMES  = 1024,
    parameter int STACK_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  flcs_pkg::item_t                item,
    input  logic [flcs_pkg::COUNT_W-1:0]   live_count,
    output logic                           res_valid,
    input  logic                           res_ready,
    output flcs_pkg::result_t              res
);

    localparam int FRAME_AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SA_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int CW       = flcs_pkg::COUNT_W;
    localparam int FW       = flcs_pkg::FRAME_W;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_PRI_CHK = 4'd2;
    localparam logic [3:0] S_QRY_CHK = 4'd3;
    localparam logic [3:0] S_WALK    = 4'd4;
    localparam logic [3:0] S_POP_CHK = 4'd5;
    localparam logic [3:0] S_MAP_CHK = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [FRAME_AW-1:0] clr_reg, clr_next;
    logic [SP_W-1:0]     fill_reg, fill_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       cand_reg, cand_next;
    flcs_pkg::result_t   res_reg, res_next;

    logic [FRAME_AW-1:0] map_addr;
    logic                map_wdata;
    logic                loaded_we, claimed_we;
    logic                loaded_rdata, claimed_rdata;
    logic                stk_we;
    logic [SA_W-1:0]     stk_addr;
    logic [FW-1:0]       stk_rdata;
    logic                in_range;

    flcs_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_loaded_ram (
        .clk   (clk),
        .we    (loaded_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (loaded_rdata)
    );

    flcs_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_claimed_ram (
        .clk   (clk),
        .we    (claimed_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (claimed_rdata)
    );

    flcs_ram #(.WIDTH(FW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (cand_reg[FW-1:0]),
        .rdata (stk_rdata)
    );

    assign in_range  = CW'(item.frame_index) < live_count;
    assign map_wdata = (state_reg != S_CLEAR);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        fill_next   = fill_reg;
        cursor_next = cursor_reg;
        cand_next   = cand_reg;
        res_next    = res_reg;
        map_addr    = FRAME_AW'(cand_reg);
        loaded_we   = 1'b0;
        claimed_we  = 1'b0;
        stk_we      = 1'b0;
        stk_addr    = SA_W'(fill_reg);
        item_ready  = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                map_addr   = clr_reg;
                loaded_we  = 1'b1;
                claimed_we = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == FRAME_AW'(MAX_FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                map_addr   = FRAME_AW'(item.frame_index);
                if (item_valid)
                begin
                    cand_next = CW'(item.frame_index);
                    res_next  = '0;
                    case (item.func)
                        flcs_pkg::FN_PRIORITIZE:
                        begin
                            state_next = in_range ? S_PRI_CHK : S_DONE;
                        end
                        flcs_pkg::FN_CLAIM:
                        begin
                            state_next = S_WALK;
                        end
                        flcs_pkg::FN_MARK:
                        begin
                            loaded_we  = in_range;
                            state_next = S_DONE;
                        end
                        flcs_pkg::FN_QUERY:
                        begin
                            state_next = in_range ? S_QRY_CHK : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PRI_CHK:
            begin
                if (!loaded_rdata && !claimed_rdata)
                begin
                    if (fill_reg < SP_W'(STACK_DEPTH))
                    begin
                        stk_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        res_next.push_refused = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_QRY_CHK:
            begin
                res_next.is_loaded = loaded_rdata;
                state_next         = S_DONE;
            end
            S_WALK:
            begin
                // drain the priority stack first, then advance the cursor
                if (fill_reg != '0)
                begin
                    stk_addr   = SA_W'(fill_reg - 1'b1);
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_POP_CHK;
                end
                else if (cursor_reg < live_count)
                begin
                    map_addr    = FRAME_AW'(cursor_reg);
                    cand_next   = cursor_reg;
                    cursor_next = cursor_reg + 1'b1;
                    state_next  = S_MAP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_CHK:
            begin
                cand_next = CW'(stk_rdata);
                map_addr  = FRAME_AW'(stk_rdata);
                // drop stale entries beyond the live frame count
                state_next = (CW'(stk_rdata) < live_count) ? S_MAP_CHK : S_WALK;
            end
            S_MAP_CHK:
            begin
                if (!loaded_rdata && !claimed_rdata)
                begin
                    claimed_we             = 1'b1;
                    res_next.claimed_frame = cand_reg[FW-1:0];
                    res_next.claim_found   = 1'b1;
                    state_next             = S_DONE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            fill_reg   <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            fill_reg   <= fill_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- src/frame_load_claim_scheduler_top.sv -----
// Frame load claim scheduler: hands out frame numbers to loaders.
//
// Channels: req carries one transaction per request (func, frame_index);
// rsp returns exactly one transaction per request; cfg writes frame_count,
// and is always ready. Write cfg only while no request is outstanding.
// After reset the loaded and claimed maps are swept clear, one frame per
// cycle; req.ready stays low until the sweep is done.
// Requests are handled one at a time by a sequencer around the map and
// stack memories, each with a registered read. Mark loaded goes straight
// to the response; prioritize and query read the maps first; claim pops
// the priority stack, dropping stale entries, then walks the cursor over
// the frames, checking each candidate in the maps. The walk sets the
// claim time. req.ready rises as the response enters the output
// register. A stalled rsp holds that register, and a second finished
// response waits inside the sequencer until the register frees.
module frame_load_claim_scheduler_top #(
    parameter int MAX_FRAMES  = 1024,
    parameter int STACK_DEPTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    flcs_req_if.sink  req,
    flcs_rsp_if.source rsp,
    flcs_cfg_if.sink  cfg
);

    localparam int CW       = flcs_pkg::COUNT_W;
    localparam int LIVE_CAP = (MAX_FRAMES > 2047) ? 2047 : MAX_FRAMES;

    logic [CW-1:0]     frame_count_reg;
    logic [CW-1:0]     live_count;
    logic              rsp_valid_reg;
    flcs_pkg::result_t rsp_data_reg;
    flcs_pkg::item_t   item;
    flcs_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;

    assign cfg.ready = 1'b1;

    // frame counts above the frame store act as its size
    assign live_count = (frame_count_reg > CW'(LIVE_CAP)) ? CW'(LIVE_CAP) : frame_count_reg;

    assign item.func        = req.func;
    assign item.frame_index = req.frame_index;

    flcs_ctrl #(
        .MAX_FRAMES  (MAX_FRAMES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .item       (item),
        .live_count (live_count),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                frame_count_reg <= cfg.frame_count;
            end
            if (res_ready)
            begin
                rsp_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.claimed_frame = rsp_data_reg.claimed_frame;
    assign rsp.claim_found   = rsp_data_reg.claim_found;
    assign rsp.is_loaded     = rsp_data_reg.is_loaded;
    assign rsp.push_refused  = rsp_data_reg.push_refused;

endmodule

// ----- src/flcs_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
module flcs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [flcs_pkg::FRAME_W-1:0]   rsp_claimed_frame,
    input logic                           rsp_claim_found,
    input logic                           rsp_is_loaded,
    input logic                           rsp_push_refused
);

    // hold a response until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // ready is low in the cycle after each accepted request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in progress");

    a_no_frame_without_claim: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_claim_found |-> rsp_claimed_frame == '0)
        else $error("frame number reported without a claim");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $countones({rsp_claim_found, rsp_is_loaded, rsp_push_refused}) <= 1)
        else $error("more than one result flag set");

endmodule

bind frame_load_claim_scheduler_top flcs_checker u_flcs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_claimed_frame (rsp.claimed_frame),
    .rsp_claim_found   (rsp.claim_found),
    .rsp_is_loaded     (rsp.is_loaded),
    .rsp_push_refused  (rsp.push_refused)
);

// ----- tb/tb_frame_load_claim_scheduler_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the frame load claim scheduler: directed and random requests.
module tb_frame_load_claim_scheduler_top;

    localparam int MAX_FRAMES    = 1024;
    localparam int STACK_DEPTH   = 16;
    localparam int CYCLE_LIMIT   = 10000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 72;
    localparam int FW            = flcs_pkg::FRAME_W;
    localparam int CW            = flcs_pkg::COUNT_W;
    localparam int FNW           = flcs_pkg::FUNC_W;

    logic clk;
    logic rst_n;

    flcs_req_if req_ch ();
    flcs_rsp_if rsp_ch ();
    flcs_cfg_if cfg_ch ();

    frame_load_claim_scheduler_top #(
        .MAX_FRAMES  (MAX_FRAMES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Scheduler state as the testbench sees it
    logic [MAX_FRAMES-1:0] loaded_mark;
    logic [MAX_FRAMES-1:0] claimed_mark;
    logic [FW-1:0]         prio_stack [STACK_DEPTH];
    int                    stack_used;
    int                    scan_pos;
    logic [CW-1:0]         frame_total;

    flcs_pkg::result_t pending_replies [$];
    flcs_pkg::result_t want;

    bit tx_idle_en;
    bit rx_stall_en;
    int rx_hold_cycles;

    int fail_count;
    int sent_count;
    int replies_checked;
    int claims_found;
    int pushes_refused;
    int count_writes;
    int cycles;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic int frames_in_play();
        return (frame_total > MAX_FRAMES) ? MAX_FRAMES : int'(frame_total);
    endfunction

    function automatic bit frame_usable(input int f);
        return f < frames_in_play() && !loaded_mark[f] && !claimed_mark[f];
    endfunction

    function automatic flcs_pkg::result_t apply_request(input logic [FNW-1:0] fn,
                                                        input logic [FW-1:0] idx);
        flcs_pkg::result_t r;
        int                e;
        r = '0;
        case (fn)
            flcs_pkg::FN_PRIORITIZE:
            begin
                if (frame_usable(int'(idx)))
                begin
                    if (stack_used < STACK_DEPTH)
                    begin
                        prio_stack[stack_used] = idx;
                        stack_used++;
                    end
                    else
                    begin
                        r.push_refused = 1'b1;
                    end
                end
            end
            flcs_pkg::FN_CLAIM:
            begin
                // Pop priority entries first, then walk the cursor
                while (!r.claim_found && stack_used > 0)
                begin
                    stack_used--;
                    e = int'(prio_stack[stack_used]);
                    if (frame_usable(e))
                    begin
                        claimed_mark[e] = 1'b1;
                        r.claimed_frame = FW'(e);
                        r.claim_found   = 1'b1;
                    end
                end
                while (!r.claim_found && scan_pos < frames_in_play())
                begin
                    e = scan_pos;
                    scan_pos++;
                    if (frame_usable(e))
                    begin
                        claimed_mark[e] = 1'b1;
                        r.claimed_frame = FW'(e);
                        r.claim_found   = 1'b1;
                    end
                end
            end
            flcs_pkg::FN_MARK:
            begin
                if (int'(idx) < frames_in_play())
                    loaded_mark[idx] = 1'b1;
            end
            default:
            begin
                if (int'(idx) < frames_in_play())
                    r.is_loaded = loaded_mark[idx];
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // Leaves valid high on acceptance; the caller lowers it or sends again in the same step
    task automatic send_request(input logic [FNW-1:0] fn, input logic [FW-1:0] idx);
        int                gap;
        flcs_pkg::result_t reply;
        gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= fn;
        req_ch.frame_index <= idx;
        do @(posedge clk); while (!req_ch.ready);
        reply = apply_request(fn, idx);
        pending_replies = {pending_replies, reply};
        sent_count++;
    endtask

    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Call only with nothing outstanding
    task automatic set_frame_count(input logic [CW-1:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.frame_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        frame_total = value;
        count_writes++;
    endtask

    task automatic random_request();
        int             r;
        int             live;
        logic [FNW-1:0] fn;
        logic [FW-1:0]  idx;
        live = frames_in_play();
        r = $urandom_range(0, 99);
        if (r < 35)
            fn = flcs_pkg::FN_PRIORITIZE;
        else if (r < 65)
            fn = flcs_pkg::FN_CLAIM;
        else if (r < 82)
            fn = flcs_pkg::FN_MARK;
        else
            fn = flcs_pkg::FN_QUERY;
        if (live > 0 && $urandom_range(0, 6) != 0)
            idx = FW'($urandom_range(0, live - 1));
        else
            idx = FW'($urandom_range(0, MAX_FRAMES - 1));
        send_request(fn, idx);
    endtask

    task automatic test_empty_sequence();
        // Frame count is still zero from reset: every frame is out of range
        send_request(flcs_pkg::FN_QUERY, 10'd1023);
        send_request(flcs_pkg::FN_MARK, 10'd0);
        send_request(flcs_pkg::FN_PRIORITIZE, 10'd0);
        send_request(flcs_pkg::FN_CLAIM, 10'h3FF);
        wait_for_replies();
    endtask

    task automatic test_small_sequence();
        set_frame_count(11'd8);
        send_request(flcs_pkg::FN_PRIORITIZE, 10'd3);
        send_request(flcs_pkg::FN_PRIORITIZE, 10'd3);
        send_request(flcs_pkg::FN_PRIORITIZE, 10'd7);
        send_request(flcs_pkg::FN_MARK, 10'd7);
        send_request(flcs_pkg::FN_CLAIM, 10'd0);
        send_request(flcs_pkg::FN_CLAIM, 10'd0);
        send_request(flcs_pkg::FN_QUERY, 10'd7);
        send_request(flcs_pkg::FN_QUERY, 10'd8);
        send_request(flcs_pkg::FN_PRIORITIZE, 10'd0);
        wait_for_replies();
    endtask

    task automatic test_full_stack();
        set_frame_count(11'd2047);
        send_request(flcs_pkg::FN_MARK, 10'd1023);
        send_request(flcs_pkg::FN_QUERY, 10'd1023);
        repeat (STACK_DEPTH + 1) send_request(flcs_pkg::FN_PRIORITIZE, 10'd1022);
        wait_for_replies();
        // Shrink the sequence so every stacked entry goes stale
        set_frame_count(11'd1000);
        send_request(flcs_pkg::FN_CLAIM, 10'd0);
        wait_for_replies();
        set_frame_count(11'd0);
        send_request(flcs_pkg::FN_CLAIM, 10'd0);
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        set_frame_count(11'd200);
        tx_idle_en     = 1'b0;
        rx_hold_cycles = 400;
        repeat (24) random_request();
        wait_for_replies();
        tx_idle_en = 1'b1;
        repeat (12) random_request();
        wait_for_replies();
    endtask

    task automatic test_random_mix();
        int r;
        int n;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                set_frame_count(CW'($urandom_range(1, 48)));
            else if (r == 6)
                set_frame_count(11'd1024);
            else if (r == 7)
                set_frame_count(CW'($urandom_range(1025, 2047)));
            else if (r == 8)
                set_frame_count(CW'($urandom_range(0, 1023)));
            else
                set_frame_count(CW'($urandom_range(0, 16)));
            tx_idle_en  = (p % 4) != 0;
            rx_stall_en = (p % 3) != 1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                // Now and then a burst of pushes to run the stack into its limit
                if ($urandom_range(0, 14) == 0 && frames_in_play() > 0)
                begin
                    repeat (STACK_DEPTH + 2)
                        send_request(flcs_pkg::FN_PRIORITIZE,
                                     FW'($urandom_range(0, frames_in_play() - 1)));
                    n += STACK_DEPTH + 2;
                end
                else
                begin
                    random_request();
                    n++;
                end
            end
            wait_for_replies();
        end
    endtask

    // Response side: random stalls, and a long hold when a test asks for one
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_stall_en && $urandom_range(0, 3) == 0)
            begin
                n = idle_len();
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected response transaction: claimed_frame %0d found %0b",
                       rsp_ch.claimed_frame, rsp_ch.claim_found);
                fail_count++;
            end
            else
            begin
                want = pending_replies[0];
                pending_replies.delete(0);
                check_field("claimed_frame", 32'(want.claimed_frame),
                            32'(rsp_ch.claimed_frame));
                check_field("claim_found", 32'(want.claim_found), 32'(rsp_ch.claim_found));
                check_field("is_loaded", 32'(want.is_loaded), 32'(rsp_ch.is_loaded));
                check_field("push_refused", 32'(want.push_refused),
                            32'(rsp_ch.push_refused));
                replies_checked++;
                if (want.claim_found)
                    claims_found++;
                if (want.push_refused)
                    pushes_refused++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d responses pending",
                     cycles, pending_replies.size());
            $display("tb_frame_load_claim_scheduler_top failed");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = flcs_pkg::FN_QUERY;
        req_ch.frame_index = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.frame_count = '0;
        loaded_mark        = '0;
        claimed_mark       = '0;
        stack_used         = 0;
        scan_pos           = 0;
        frame_total        = '0;
        tx_idle_en         = 1'b1;
        rx_stall_en        = 1'b1;
        rx_hold_cycles     = 0;
        fail_count         = 0;
        sent_count         = 0;
        replies_checked    = 0;
        claims_found       = 0;
        pushes_refused     = 0;
        count_writes       = 0;
        cycles             = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_sequence();
        test_small_sequence();
        test_full_stack();
        test_backpressure();
        test_random_mix();
        wait_for_replies();

        $display("Checked %0d responses to %0d requests across %0d frame-count settings",
                 replies_checked, sent_count, count_writes);
        $display("Claims handed out: %0d, pushes refused on a full stack: %0d",
                 claims_found, pushes_refused);
        if (fail_count == 0 && pending_replies.size() == 0)
        begin
            $display("tb_frame_load_claim_scheduler_top passed");
        end
        else
        begin
            if (pending_replies.size() != 0)
                $error("%0d expected responses never arrived", pending_replies.size());
            $display("tb_frame_load_claim_scheduler_top failed");
        end
        $finish;
    end

endmodule
